// ----- rtl/bmi_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmi_pkg
// Shared types and constants for the bilinear map interpolation block.
// ----------------------------------------------------------------------------
package bmi_pkg;

   // default map geometry
   localparam int DEF_MAX_ROWS = 16;
   localparam int DEF_MAX_COLS = 16;

   // value and index widths of the ports
   localparam int VAL_W      = 16;
   localparam int IDX_W      = 4;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 5;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_ROWS = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_COLS = 2'd1;

   // count after reset
   localparam int RESET_COUNT = 16;

   // item kinds
   localparam logic MODE_QUERY = 1'b0;
   localparam logic MODE_WRITE = 1'b1;

   // command to the shared interpolation unit
   typedef struct packed {
      logic                    start;
      logic signed [VAL_W-1:0] q;
      logic signed [VAL_W-1:0] q0;
      logic signed [VAL_W-1:0] q1;
      logic signed [VAL_W-1:0] v0;
      logic signed [VAL_W-1:0] v1;
   } lerp_cmd_type;

   // status back from the interpolation unit
   typedef struct packed {
      logic                    done;
      logic signed [VAL_W-1:0] result;
   } lerp_rsp_type;

   // count clamped into [2, maxv]
   function automatic int clamp_cnt(input int v, input int maxv);
      int r;
      r = v;
      if (v < 2) r = 2;
      else if (v > maxv) r = maxv;
      return r;
   endfunction

endpackage

// ----- rtl/bilinear_map_interpolation.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bilinear_map_interpolation
// 2D calibration map with bracket search and bilinear interpolation.
//
//   channel   direction  handshake           payload
//   req_      in         req_valid/req_ready mode, indices, entry, x, y
//   rsp_      out        rsp_valid/rsp_ready interpolated_value
//   csr_      in         csr_we              index, wdata
//
// A write is done in its transfer and leaves the block idle. A query searches
// up to rows-1 entries of column 0 for y and cols-1 entries of row 0 for x,
// makes the eight map reads and three passes through the shared serial
// divider (which a zero span skips), before the next transfer is taken.
// req_ready is high only while idle; a finished result waits in the output
// register for rsp_ready. Reset clears control state only; map entries hold
// no value until written.
// ----------------------------------------------------------------------------
module bilinear_map_interpolation #(
   parameter int MAX_ROWS = bmi_pkg::DEF_MAX_ROWS,
   parameter int MAX_COLS = bmi_pkg::DEF_MAX_COLS
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic                             req_mode,
   input  logic [bmi_pkg::IDX_W-1:0]        req_row_index,
   input  logic [bmi_pkg::IDX_W-1:0]        req_col_index,
   input  logic signed [bmi_pkg::VAL_W-1:0] req_entry_value,
   input  logic signed [bmi_pkg::VAL_W-1:0] req_x_query,
   input  logic signed [bmi_pkg::VAL_W-1:0] req_y_query,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic signed [bmi_pkg::VAL_W-1:0] rsp_interpolated_value,
   input  logic                             csr_we,
   input  logic [bmi_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [bmi_pkg::CSR_DATA_W-1:0]   csr_wdata
);
   import bmi_pkg::*;

   localparam int RIW   = $clog2(MAX_ROWS);
   localparam int CIW   = $clog2(MAX_COLS);
   localparam int KW    = (RIW > CIW) ? RIW : CIW;
   localparam int RCW   = $clog2(MAX_ROWS + 1);
   localparam int CCW   = $clog2(MAX_COLS + 1);
   localparam int DEPTH = MAX_ROWS * MAX_COLS;
   localparam int AW    = $clog2(DEPTH);

   // sequencer states
   localparam logic [3:0] ST_IDLE  = 4'd0;
   localparam logic [3:0] ST_YRD   = 4'd1;
   localparam logic [3:0] ST_YCMP  = 4'd2;
   localparam logic [3:0] ST_XRD   = 4'd3;
   localparam logic [3:0] ST_XCMP  = 4'd4;
   localparam logic [3:0] ST_LOAD  = 4'd5;
   localparam logic [3:0] ST_LGO   = 4'd6;
   localparam logic [3:0] ST_LWAIT = 4'd7;
   localparam logic [3:0] ST_DONE  = 4'd8;

   // interpolation passes
   localparam logic [1:0] PH_AB = 2'd0;
   localparam logic [1:0] PH_CD = 2'd1;
   localparam logic [1:0] PH_Y  = 2'd2;

   // slots of the loaded operands
   localparam logic [2:0] V_X0 = 3'd0;
   localparam logic [2:0] V_X1 = 3'd1;
   localparam logic [2:0] V_Y0 = 3'd2;
   localparam logic [2:0] V_Y1 = 3'd3;
   localparam logic [2:0] V_A  = 3'd4;
   localparam logic [2:0] V_B  = 3'd5;
   localparam logic [2:0] V_C  = 3'd6;
   localparam logic [2:0] V_D  = 3'd7;
   localparam logic [3:0] LOAD_LAST = 4'd8;

   function automatic logic [AW-1:0] addr_of(input int unsigned r, input int unsigned c);
      return AW'(r * MAX_COLS + c);
   endfunction

   logic [3:0]              state_ff, state_in;
   logic [KW-1:0]           k_ff, k_in;
   logic signed [VAL_W-1:0] qx_ff, qx_in;
   logic signed [VAL_W-1:0] qy_ff, qy_in;
   logic [RIW-1:0]          rlo_ff, rlo_in, rhi_ff, rhi_in;
   logic [CIW-1:0]          clo_ff, clo_in, chi_ff, chi_in;
   logic signed [VAL_W-1:0] vals_ff [8];
   logic signed [VAL_W-1:0] vals_in [8];
   logic signed [VAL_W-1:0] fab_ff, fab_in, fcd_ff, fcd_in;
   logic [3:0]              ld_ff, ld_in;
   logic [1:0]              ph_ff, ph_in;
   logic [RCW-1:0]          rows_ff, rows_in;
   logic [CCW-1:0]          cols_ff, cols_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic signed [VAL_W-1:0] rsp_val_ff, rsp_val_in;

   logic                    ram_we;
   logic [AW-1:0]           ram_waddr;
   logic [AW-1:0]           ram_raddr;
   logic [VAL_W-1:0]        ram_rdata;
   logic signed [VAL_W-1:0] t;
   lerp_cmd_type            lcmd;
   lerp_rsp_type            lrsp;
   logic                    y_last, x_last;

   bmi_ram #(
      .WIDTH (VAL_W),
      .DEPTH (DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (req_entry_value),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   bmi_lerp u_lerp (
      .clock (clock),
      .reset (reset),
      .cmd   (lcmd),
      .rsp   (lrsp)
   );

   assign t         = ram_rdata;
   assign ram_waddr = addr_of(32'(req_row_index), 32'(req_col_index));
   assign y_last    = ((KW+1)'(k_ff) + (KW+1)'(1)) == (KW+1)'(rows_ff);
   assign x_last    = ((KW+1)'(k_ff) + (KW+1)'(1)) == (KW+1)'(cols_ff);

   // configuration writes, counts held clamped
   always_comb begin
      rows_in = rows_ff;
      cols_in = cols_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_ROWS: rows_in = RCW'(clamp_cnt(32'(csr_wdata), MAX_ROWS));
            CSR_COLS: cols_in = CCW'(clamp_cnt(32'(csr_wdata), MAX_COLS));
            default: ;
         endcase
      end
   end

   // query sequencer
   always_comb begin
      state_in     = state_ff;
      k_in         = k_ff;
      qx_in        = qx_ff;
      qy_in        = qy_ff;
      rlo_in       = rlo_ff;
      rhi_in       = rhi_ff;
      clo_in       = clo_ff;
      chi_in       = chi_ff;
      vals_in      = vals_ff;
      fab_in       = fab_ff;
      fcd_in       = fcd_ff;
      ld_in        = ld_ff;
      ph_in        = ph_ff;
      rsp_val_in   = rsp_val_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      req_ready    = 1'b0;
      ram_we       = 1'b0;
      ram_raddr    = '0;
      lcmd         = '0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               if (req_mode == MODE_WRITE) begin
                  ram_we = (32'(req_row_index) < MAX_ROWS) &&
                           (32'(req_col_index) < MAX_COLS);
               end else begin
                  qx_in    = req_x_query;
                  qy_in    = req_y_query;
                  k_in     = KW'(1);
                  state_in = ST_YRD;
               end
            end
         end
         ST_YRD: begin
            ram_raddr = addr_of(32'(k_ff), 0);
            state_in  = ST_YCMP;
         end
         ST_YCMP: begin
            if (qy_ff <= t) begin
               rhi_in   = RIW'(k_ff);
               rlo_in   = (qy_ff == t || k_ff == KW'(1)) ? RIW'(k_ff) : RIW'(k_ff - KW'(1));
               k_in     = KW'(1);
               state_in = ST_XRD;
            end else if (y_last) begin
               rhi_in   = RIW'(k_ff);
               rlo_in   = RIW'(k_ff);
               k_in     = KW'(1);
               state_in = ST_XRD;
            end else begin
               k_in     = k_ff + KW'(1);
               state_in = ST_YRD;
            end
         end
         ST_XRD: begin
            ram_raddr = addr_of(0, 32'(k_ff));
            state_in  = ST_XCMP;
         end
         ST_XCMP: begin
            if (qx_ff <= t) begin
               chi_in   = CIW'(k_ff);
               clo_in   = (qx_ff == t || k_ff == KW'(1)) ? CIW'(k_ff) : CIW'(k_ff - KW'(1));
               ld_in    = '0;
               state_in = ST_LOAD;
            end else if (x_last) begin
               chi_in   = CIW'(k_ff);
               clo_in   = CIW'(k_ff);
               ld_in    = '0;
               state_in = ST_LOAD;
            end else begin
               k_in     = k_ff + KW'(1);
               state_in = ST_XRD;
            end
         end
         ST_LOAD: begin
            // read data for an address is taken in the cycle after it is issued
            case (ld_ff[2:0])
               V_X0:    ram_raddr = addr_of(0, 32'(clo_ff));
               V_X1:    ram_raddr = addr_of(0, 32'(chi_ff));
               V_Y0:    ram_raddr = addr_of(32'(rlo_ff), 0);
               V_Y1:    ram_raddr = addr_of(32'(rhi_ff), 0);
               V_A:     ram_raddr = addr_of(32'(rlo_ff), 32'(clo_ff));
               V_B:     ram_raddr = addr_of(32'(rlo_ff), 32'(chi_ff));
               V_C:     ram_raddr = addr_of(32'(rhi_ff), 32'(clo_ff));
               V_D:     ram_raddr = addr_of(32'(rhi_ff), 32'(chi_ff));
               default: ram_raddr = '0;
            endcase
            if (ld_ff != 4'd0) begin
               vals_in[3'(ld_ff - 4'd1)] = t;
            end
            ld_in = ld_ff + 4'd1;
            if (ld_ff == LOAD_LAST) begin
               ph_in    = PH_AB;
               state_in = ST_LGO;
            end
         end
         ST_LGO: begin
            lcmd.start = 1'b1;
            case (ph_ff)
               PH_AB: begin
                  lcmd.q  = qx_ff;
                  lcmd.q0 = vals_ff[V_X0];
                  lcmd.q1 = vals_ff[V_X1];
                  lcmd.v0 = vals_ff[V_A];
                  lcmd.v1 = vals_ff[V_B];
               end
               PH_CD: begin
                  lcmd.q  = qx_ff;
                  lcmd.q0 = vals_ff[V_X0];
                  lcmd.q1 = vals_ff[V_X1];
                  lcmd.v0 = vals_ff[V_C];
                  lcmd.v1 = vals_ff[V_D];
               end
               default: begin
                  lcmd.q  = qy_ff;
                  lcmd.q0 = vals_ff[V_Y0];
                  lcmd.q1 = vals_ff[V_Y1];
                  lcmd.v0 = fab_ff;
                  lcmd.v1 = fcd_ff;
               end
            endcase
            state_in = ST_LWAIT;
         end
         ST_LWAIT: begin
            if (lrsp.done) begin
               case (ph_ff)
                  PH_AB: begin
                     fab_in   = lrsp.result;
                     ph_in    = PH_CD;
                     state_in = ST_LGO;
                  end
                  PH_CD: begin
                     fcd_in   = lrsp.result;
                     ph_in    = PH_Y;
                     state_in = ST_LGO;
                  end
                  default: begin
                     fab_in   = lrsp.result;
                     state_in = ST_DONE;
                  end
               endcase
            end
         end
         ST_DONE: begin
            // final value sits in fab until the output register is free
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_val_in   = fab_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         rows_ff      <= RCW'(clamp_cnt(RESET_COUNT, MAX_ROWS));
         cols_ff      <= CCW'(clamp_cnt(RESET_COUNT, MAX_COLS));
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         rows_ff      <= rows_in;
         cols_ff      <= cols_in;
      end
      k_ff       <= k_in;
      qx_ff      <= qx_in;
      qy_ff      <= qy_in;
      rlo_ff     <= rlo_in;
      rhi_ff     <= rhi_in;
      clo_ff     <= clo_in;
      chi_ff     <= chi_in;
      vals_ff    <= vals_in;
      fab_ff     <= fab_in;
      fcd_ff     <= fcd_in;
      ld_ff      <= ld_in;
      ph_ff      <= ph_in;
      rsp_val_ff <= rsp_val_in;
   end

   assign rsp_valid              = rsp_valid_ff;
   assign rsp_interpolated_value = rsp_val_ff;

endmodule

// ----- rtl/bmi_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmi_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module bmi_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/bmi_lerp.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmi_lerp
// Shared interpolation unit: v0 + (q - q0) * (v1 - v0) / (q1 - q0), one
// registered multiply then a one-bit-per-cycle restoring divide.
// ----------------------------------------------------------------------------
module bmi_lerp (
   input  logic                  clock,
   input  logic                  reset,
   input  bmi_pkg::lerp_cmd_type cmd,
   output bmi_pkg::lerp_rsp_type rsp
);
   import bmi_pkg::*;

   localparam logic [2:0] L_IDLE = 3'd0;
   localparam logic [2:0] L_MUL  = 3'd1;
   localparam logic [2:0] L_ABS  = 3'd2;
   localparam logic [2:0] L_DIV  = 3'd3;
   localparam logic [2:0] L_FIN  = 3'd4;

   localparam int DW = VAL_W + 1;   // width of a difference
   localparam int PW = 32;          // product width

   logic [2:0]           state_ff, state_in;
   logic signed [DW-1:0] span_ff, span_in;
   logic signed [DW-1:0] diff_ff, diff_in;
   logic signed [DW-1:0] dv_ff, dv_in;
   logic [VAL_W-1:0]     v0_ff, v0_in;
   logic signed [PW-1:0] prod_ff, prod_in;
   logic [PW-1:0]        dvd_ff, dvd_in;
   logic [DW-1:0]        dvs_ff, dvs_in;
   logic [DW-1:0]        rem_ff, rem_in;
   logic                 neg_ff, neg_in;
   logic [4:0]           cnt_ff, cnt_in;
   logic                 done_ff, done_in;
   logic [VAL_W-1:0]     res_ff, res_in;

   logic signed [2*DW-1:0] full_prod;
   logic [DW:0]            rem_shift;
   logic [DW:0]            rem_sub;
   logic [PW-1:0]          quot_s;

   assign full_prod = diff_ff * dv_ff;
   assign rem_shift = {rem_ff, dvd_ff[PW-1]};
   assign rem_sub   = rem_shift - {1'b0, dvs_ff};
   assign quot_s    = neg_ff ? (~dvd_ff + PW'(1)) : dvd_ff;

   // sequencer of the unit
   always_comb begin
      state_in = state_ff;
      span_in  = span_ff;
      diff_in  = diff_ff;
      dv_in    = dv_ff;
      v0_in    = v0_ff;
      prod_in  = prod_ff;
      dvd_in   = dvd_ff;
      dvs_in   = dvs_ff;
      rem_in   = rem_ff;
      neg_in   = neg_ff;
      cnt_in   = cnt_ff;
      done_in  = 1'b0;
      res_in   = res_ff;
      case (state_ff)
         L_IDLE: begin
            if (cmd.start) begin
               span_in = {cmd.q1[VAL_W-1], cmd.q1} - {cmd.q0[VAL_W-1], cmd.q0};
               diff_in = {cmd.q[VAL_W-1], cmd.q} - {cmd.q0[VAL_W-1], cmd.q0};
               dv_in   = {cmd.v1[VAL_W-1], cmd.v1} - {cmd.v0[VAL_W-1], cmd.v0};
               v0_in   = cmd.v0;
               if (cmd.q1 == cmd.q0) begin
                  // zero span: take the lower value
                  res_in  = cmd.v0;
                  done_in = 1'b1;
               end else begin
                  state_in = L_MUL;
               end
            end
         end
         L_MUL: begin
            prod_in  = full_prod[PW-1:0];
            state_in = L_ABS;
         end
         L_ABS: begin
            dvd_in   = prod_ff[PW-1] ? (~prod_ff + PW'(1)) : prod_ff;
            dvs_in   = span_ff[DW-1] ? (~span_ff + DW'(1)) : span_ff;
            neg_in   = prod_ff[PW-1] ^ span_ff[DW-1];
            rem_in   = '0;
            cnt_in   = '0;
            state_in = L_DIV;
         end
         L_DIV: begin
            // one quotient bit per cycle, shifted into the dividend register
            if (!rem_sub[DW]) begin
               rem_in = rem_sub[DW-1:0];
               dvd_in = {dvd_ff[PW-2:0], 1'b1};
            end else begin
               rem_in = rem_shift[DW-1:0];
               dvd_in = {dvd_ff[PW-2:0], 1'b0};
            end
            cnt_in = cnt_ff + 5'd1;
            if (cnt_ff == 5'd31) begin
               state_in = L_FIN;
            end
         end
         L_FIN: begin
            res_in   = quot_s[VAL_W-1:0] + v0_ff;
            done_in  = 1'b1;
            state_in = L_IDLE;
         end
         default: begin
            state_in = L_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= L_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
      span_ff <= span_in;
      diff_ff <= diff_in;
      dv_ff   <= dv_in;
      v0_ff   <= v0_in;
      prod_ff <= prod_in;
      dvd_ff  <= dvd_in;
      dvs_ff  <= dvs_in;
      rem_ff  <= rem_in;
      neg_ff  <= neg_in;
      cnt_ff  <= cnt_in;
      res_ff  <= res_in;
   end

   assign rsp.done   = done_ff;
   assign rsp.result = res_ff;

endmodule

// ----- rtl/bmi_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmi_checker
// Port-level checks on the bilinear map interpolation block, bound to it.
// ----------------------------------------------------------------------------
module bmi_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             req_valid,
   input logic                             req_ready,
   input logic                             req_mode,
   input logic                             rsp_valid,
   input logic                             rsp_ready,
   input logic signed [bmi_pkg::VAL_W-1:0] rsp_interpolated_value
);
   import bmi_pkg::*;

   // a held result keeps its value
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_interpolated_value))
      else $error("result changed while stalled");

   // a query keeps the block busy after its transfer
   a_query_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_mode == MODE_QUERY |=> !req_ready)
      else $error("ready after query transfer");

   // a write gives no result
   a_write_silent: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_mode == MODE_WRITE && !rsp_valid |=> !rsp_valid)
      else $error("result after write");

   // a new result only appears while the block is busy
   a_rsp_from_busy: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(!req_ready))
      else $error("result raised while idle");

   // reset clears the output
   a_reset_clear: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

endmodule

bind bilinear_map_interpolation bmi_checker u_bmi_checker (
   .clock                  (clock),
   .reset                  (reset),
   .req_valid              (req_valid),
   .req_ready              (req_ready),
   .req_mode               (req_mode),
   .rsp_valid              (rsp_valid),
   .rsp_ready              (rsp_ready),
   .rsp_interpolated_value (rsp_interpolated_value)
);
